// ----- src/w2s_pkg.sv -----
`timescale 1ns / 1ps

package w2s_pkg;

  // fixed formats of the ports
  localparam int COEF_W           = 16;
  localparam int COORD_W          = 32;
  localparam int OUT_W            = 32;
  localparam int SCALE_W          = 16;
  localparam int CFG_W            = 64;
  localparam int CFG_IDX_W        = 3;
  localparam int MAT_N            = 4;
  localparam int LANES            = 2;

  // fixed point scaling
  localparam int COEF_FRAC_BITS   = 12;
  localparam int COORD_FRAC_BITS  = 16;
  localparam int SCREEN_FRAC_BITS = 8;

  // internal widths of the transform
  localparam int PROD_W  = COEF_W + COORD_W;
  localparam int PAIR_W  = PROD_W + 1;
  localparam int CLIP_W  = PAIR_W + 1;
  localparam int SUM_W   = CLIP_W + 1;
  localparam int MAG_W   = CLIP_W;

  // internal widths of the screen mapping
  localparam int MULT_W  = SCALE_W + SCREEN_FRAC_BITS - 1;
  localparam int HALF_W  = (MAG_W + 1) / 2;
  localparam int PART_W  = HALF_W + MULT_W;
  localparam int NUM_W   = MAG_W + MULT_W;
  localparam int QUO_W   = OUT_W;
  localparam int STEPS   = QUO_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 3'd5;

  // reset values: identity matrix, full hd screen
  localparam logic [CFG_W-1:0] ROW0_RESET = CFG_W'(1) << COEF_FRAC_BITS;
  localparam logic [CFG_W-1:0] ROW1_RESET = CFG_W'(1) << (COEF_FRAC_BITS + COEF_W);
  localparam logic [CFG_W-1:0] ROW2_RESET = CFG_W'(1) << (COEF_FRAC_BITS + 2 * COEF_W);
  localparam logic [CFG_W-1:0] ROW3_RESET = CFG_W'(1) << (COEF_FRAC_BITS + 3 * COEF_W);
  localparam logic [SCALE_W-1:0] WIDTH_RESET  = SCALE_W'(1920);
  localparam logic [SCALE_W-1:0] HEIGHT_RESET = SCALE_W'(1080);

  // homogeneous one of the world point
  localparam logic signed [COORD_W-1:0] COORD_ONE = COORD_W'(1) << COORD_FRAC_BITS;

  // saturation limits
  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic valid;
    logic visible;
  } w2s_flag_t;

  // magnitude of a signed sum, narrowed to the magnitude width
  function automatic logic [MAG_W-1:0] abs_mag(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] n;
    n = v[SUM_W-1] ? -v : v;
    return n[MAG_W-1:0];
  endfunction

endpackage

// ----- src/w2s_ratio.sv -----
`timescale 1ns / 1ps

// screen mapping: scale * num / den per lane, truncated and saturated, hidden points zeroed
module w2s_ratio
  import w2s_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  w2s_flag_t                       in_flag,
  input  logic [LANES-1:0]                in_neg,
  input  logic [LANES-1:0][MAG_W-1:0]     in_mag,
  input  logic [MAG_W-1:0]                in_den,
  input  logic [LANES-1:0][SCALE_W-1:0]   scale,
  output w2s_flag_t                       out_flag,
  output logic [LANES-1:0][OUT_W-1:0]     out_res
);

  logic [LANES-1:0][MULT_W-1:0] mult;

  w2s_flag_t                    fa;
  logic [LANES-1:0]             nega;
  logic [MAG_W-1:0]             da;
  logic [LANES-1:0][PART_W-1:0] pl;
  logic [LANES-1:0][PART_W-1:0] ph;

  w2s_flag_t                    fb;
  logic [LANES-1:0]             negb;
  logic [MAG_W-1:0]             db;
  logic [LANES-1:0][NUM_W-1:0]  num;

  w2s_flag_t                    sflag [STEPS+1];
  logic [LANES-1:0]             sneg  [STEPS+1];
  logic [LANES-1:0]             sovf  [STEPS+1];
  logic [MAG_W-1:0]             sden  [STEPS+1];
  logic [LANES-1:0][MAG_W-1:0]  srem  [STEPS+1];
  logic [LANES-1:0][QUO_W-1:0]  slo   [STEPS+1];
  logic [LANES-1:0][QUO_W-1:0]  squo  [STEPS+1];

  logic [LANES-1:0][OUT_W-1:0]  res_next;

  // pixel scale with the extra half folded in
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mult[l] = MULT_W'(scale[l]) << (SCREEN_FRAC_BITS - 1);
    end
  end

  // partial products of magnitude times scale
  always_ff @(posedge clk) begin
    if (rst) begin
      fa <= '0;
    end else if (en) begin
      fa <= in_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nega <= in_neg;
      da   <= in_den;
      for (int l = 0; l < LANES; l++) begin
        pl[l] <= PART_W'(in_mag[l][HALF_W-1:0]) * PART_W'(mult[l]);
        ph[l] <= PART_W'(in_mag[l][MAG_W-1:HALF_W]) * PART_W'(mult[l]);
      end
    end
  end

  // combine partial products into the dividend
  always_ff @(posedge clk) begin
    if (rst) begin
      fb <= '0;
    end else if (en) begin
      fb <= fa;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negb <= nega;
      db   <= da;
      for (int l = 0; l < LANES; l++) begin
        num[l] <= NUM_W'(pl[l]) + (NUM_W'(ph[l]) << HALF_W);
      end
    end
  end

  // overflow check: quotient of at least 2^32 saturates either way
  always_ff @(posedge clk) begin
    if (rst) begin
      sflag[0] <= '0;
    end else if (en) begin
      sflag[0] <= fb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sneg[0] <= negb;
      sden[0] <= db;
      for (int l = 0; l < LANES; l++) begin
        sovf[0][l] <= MAG_W'(num[l][NUM_W-1:QUO_W]) >= db;
        srem[0][l] <= (MAG_W'(num[l][NUM_W-1:QUO_W]) >= db) ? '0
                                                             : MAG_W'(num[l][NUM_W-1:QUO_W]);
        slo[0][l]  <= num[l][QUO_W-1:0];
        squo[0][l] <= '0;
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [LANES-1:0][MAG_W:0]   trial;
    logic [LANES-1:0]            take;
    logic [LANES-1:0][MAG_W-1:0] rem_next;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l]    = {srem[k][l], slo[k][l][QUO_W-1]};
        take[l]     = trial[l] >= {1'b0, sden[k]};
        rem_next[l] = take[l] ? MAG_W'(trial[l] - {1'b0, sden[k]}) : trial[l][MAG_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sflag[k+1] <= '0;
      end else if (en) begin
        sflag[k+1] <= sflag[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sneg[k+1] <= sneg[k];
        sovf[k+1] <= sovf[k];
        sden[k+1] <= sden[k];
        for (int l = 0; l < LANES; l++) begin
          srem[k+1][l] <= rem_next[l];
          slo[k+1][l]  <= slo[k][l] << 1;
          squo[k+1][l] <= {squo[k][l][QUO_W-2:0], take[l]};
        end
      end
    end
  end

  // sign, saturation and blanking of hidden points
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (!sflag[STEPS].visible) begin
        res_next[l] = '0;
      end else if (sovf[STEPS][l]) begin
        res_next[l] = sneg[STEPS][l] ? SAT_NEG : SAT_POS;
      end else if (sneg[STEPS][l]) begin
        res_next[l] = squo[STEPS][l][QUO_W-1] ? SAT_NEG : OUT_W'(-squo[STEPS][l]);
      end else begin
        res_next[l] = squo[STEPS][l][QUO_W-1] ? SAT_POS : OUT_W'(squo[STEPS][l]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_flag <= '0;
    end else if (en) begin
      out_flag <= sflag[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= res_next;
    end
  end

endmodule

// ----- src/world_to_screen_projection_top.sv -----
`timescale 1ns / 1ps

// World-to-screen projection. Each accepted world point (x, y, z, Q15.16) is multiplied
// as (x, y, z, 1) by the 4x4 view-projection matrix (Q3.12 coefficients, four per row
// register, column 0 lowest), then mapped to screen pixels in Q23.8:
// screen_x = W*(cx+cw)/(2cw), screen_y = H*(cw-cy)/(2cw), truncated toward zero and
// saturated. A point with cw of zero or |cz| > |cw| comes out with visible low and both
// coordinates zero. The pipeline takes one point per clock while the output is not
// stalled; its length is set by the 32-stage restoring divider, one quotient bit per
// stage, behind six transform stages and three scaling stages. A stall on the output
// holds the whole pipeline; the input register still takes a word while it is empty.
// The user must write registers only while the pipeline is empty; no logic enforces it.
module world_to_screen_projection_top
  import w2s_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [COORD_W-1:0]  world_x,
  input  logic signed [COORD_W-1:0]  world_y,
  input  logic signed [COORD_W-1:0]  world_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       visible,
  output logic signed [OUT_W-1:0]    screen_x,
  output logic signed [OUT_W-1:0]    screen_y
);

  logic [CFG_W-1:0]   matrix_row [MAT_N];
  logic [SCALE_W-1:0] display_width;
  logic [SCALE_W-1:0] display_height;

  logic adv;

  logic                       v1;
  logic signed [COORD_W-1:0]  x1, y1, z1;
  logic signed [COORD_W-1:0]  pt [MAT_N];
  logic signed [COEF_W-1:0]   coef [MAT_N][MAT_N];

  logic                       v2;
  logic signed [PROD_W-1:0]   prod [MAT_N][MAT_N];

  logic                       v3;
  logic signed [PAIR_W-1:0]   sa [MAT_N];
  logic signed [PAIR_W-1:0]   sb [MAT_N];

  logic                       v4;
  logic signed [CLIP_W-1:0]   clip [MAT_N];

  logic                       v5;
  logic signed [SUM_W-1:0]    numx, numy;
  logic [MAG_W-1:0]           az, aw;
  logic                       w_zero;
  logic [LANES-1:0]           neg5;

  w2s_flag_t                  flag6;
  logic [LANES-1:0]           neg6;
  logic [LANES-1:0][MAG_W-1:0] mag6;
  logic [MAG_W-1:0]           den6;

  logic [LANES-1:0][SCALE_W-1:0] scale;
  w2s_flag_t                  res_flag;
  logic [LANES-1:0][OUT_W-1:0] res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_row[0]  <= ROW0_RESET;
      matrix_row[1]  <= ROW1_RESET;
      matrix_row[2]  <= ROW2_RESET;
      matrix_row[3]  <= ROW3_RESET;
      display_width  <= WIDTH_RESET;
      display_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MATRIX_ROW0:    matrix_row[0]  <= cfg_data;
        REG_MATRIX_ROW1:    matrix_row[1]  <= cfg_data;
        REG_MATRIX_ROW2:    matrix_row[2]  <= cfg_data;
        REG_MATRIX_ROW3:    matrix_row[3]  <= cfg_data;
        REG_DISPLAY_WIDTH:  display_width  <= cfg_data[SCALE_W-1:0];
        REG_DISPLAY_HEIGHT: display_height <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline moves when the output word is empty or taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv || !v1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      x1 <= world_x;
      y1 <= world_y;
      z1 <= world_z;
    end
  end

  // matrix coefficients and homogeneous point
  always_comb begin
    pt[0] = x1;
    pt[1] = y1;
    pt[2] = z1;
    pt[3] = COORD_ONE;
    for (int r = 0; r < MAT_N; r++) begin
      for (int c = 0; c < MAT_N; c++) begin
        coef[r][c] = $signed(matrix_row[r][COEF_W*c +: COEF_W]);
      end
    end
  end

  // sixteen products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < MAT_N; r++) begin
        for (int c = 0; c < MAT_N; c++) begin
          prod[r][c] <= PROD_W'(coef[r][c]) * PROD_W'(pt[c]);
        end
      end
    end
  end

  // pairwise sums
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < MAT_N; r++) begin
        sa[r] <= PAIR_W'(prod[r][0]) + PAIR_W'(prod[r][1]);
        sb[r] <= PAIR_W'(prod[r][2]) + PAIR_W'(prod[r][3]);
      end
    end
  end

  // clip coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < MAT_N; r++) begin
        clip[r] <= CLIP_W'(sa[r]) + CLIP_W'(sb[r]);
      end
    end
  end

  // numerators, depth magnitudes and quotient signs
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      numx    <= SUM_W'(clip[0]) + SUM_W'(clip[3]);
      numy    <= SUM_W'(clip[3]) - SUM_W'(clip[1]);
      az      <= abs_mag(SUM_W'(clip[2]));
      aw      <= abs_mag(SUM_W'(clip[3]));
      w_zero  <= clip[3] == '0;
      neg5[0] <= ((SUM_W'(clip[0]) + SUM_W'(clip[3])) < 0) ^ clip[3][CLIP_W-1];
      neg5[1] <= ((SUM_W'(clip[3]) - SUM_W'(clip[1])) < 0) ^ clip[3][CLIP_W-1];
    end
  end

  // visibility test and numerator magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      flag6 <= '0;
    end else if (adv) begin
      flag6.valid   <= v5;
      flag6.visible <= !w_zero && !(az > aw);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg6    <= neg5;
      mag6[0] <= abs_mag(numx);
      mag6[1] <= abs_mag(numy);
      den6    <= aw;
    end
  end

  // screen scaling and division
  assign scale[0] = display_width;
  assign scale[1] = display_height;

  w2s_ratio u_ratio (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_flag  (flag6),
    .in_neg   (neg6),
    .in_mag   (mag6),
    .in_den   (den6),
    .scale    (scale),
    .out_flag (res_flag),
    .out_res  (res)
  );

  assign out_valid = res_flag.valid;
  assign visible   = res_flag.visible;
  assign screen_x  = $signed(res[0]);
  assign screen_y  = $signed(res[1]);

endmodule
